@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared sizes, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 4;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;

    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int TAB_W      = $clog2(TAB_STOP);
    localparam int TSUM_W     = $clog2(COLUMNS + TAB_STOP + 1);

    localparam int CELL_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int ATTR_W     = 8;
    localparam int REQ_W      = 2;
    localparam int INDEX_W    = 11;
    localparam int POS_W      = 11;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_FIELD_W = POS_W + ROW_OUT_W + COL_OUT_W + CELL_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] fore_color;
        logic [COLOR_W-1:0] back_color;
        logic [INDEX_W-1:0] cell_index;
    } t_req;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [TAB_W-1:0] phase;
    } t_cursor;

    typedef struct packed {
        t_cursor             next;
        logic                scroll;
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [CELL_W-1:0]   wr_data;
    } t_put_plan;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [CELL_W-1:0]   data;
    } t_ram_wr;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
    } t_ram_rd;

    typedef struct packed {
        logic [POS_W-1:0]     cursor_pos;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [CELL_W-1:0]    cell_data;
    } t_result;

    function automatic logic [ADDR_W-1:0] cell_base(input logic [ROW_W-1:0] row);
        return ADDR_W'(int'(row) * COLUMNS);
    endfunction

endpackage

@@ rtl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ rtl/tcw_cursor.sv @@
// ----------------------------------------------------------------------------
// tcw_cursor
// Put-character decode: next cursor, cell write and scroll request.
// ----------------------------------------------------------------------------
module tcw_cursor (
    input  tcw_pkg::t_cursor                i_cur,
    input  logic [tcw_pkg::CHAR_W-1:0]      i_char,
    input  logic [tcw_pkg::ATTR_W-1:0]      i_attr,
    output tcw_pkg::t_put_plan              o_plan
);
    import tcw_pkg::*;

    logic [ADDR_W-1:0] pos;
    logic [TSUM_W-1:0] tab_sum;

    assign pos     = cell_base(i_cur.row) + ADDR_W'(i_cur.col);
    assign tab_sum = TSUM_W'(i_cur.col) + TSUM_W'(TAB_STOP) - TSUM_W'(i_cur.phase);

    always_comb begin
        logic line_adv;
        line_adv       = 1'b0;
        o_plan.next    = i_cur;
        o_plan.scroll  = 1'b0;
        o_plan.wr_en   = 1'b0;
        o_plan.wr_addr = pos;
        o_plan.wr_data = {i_attr, i_char};
        case (i_char)
            CH_BS: begin
                if (i_cur.col != '0) begin
                    o_plan.next.col   = i_cur.col - 1'b1;
                    o_plan.next.phase = (i_cur.phase == '0) ? TAB_W'(TAB_STOP - 1)
                                                            : i_cur.phase - 1'b1;
                    o_plan.wr_en      = 1'b1;
                    o_plan.wr_addr    = pos - 1'b1;
                    o_plan.wr_data    = '0;
                end
            end
            CH_TAB: begin
                o_plan.next.phase = '0;
                if (tab_sum >= TSUM_W'(COLUMNS)) begin
                    o_plan.next.col = '0;
                    line_adv        = 1'b1;
                end else begin
                    o_plan.next.col = COL_W'(tab_sum);
                end
            end
            CH_LF: begin
                o_plan.next.col   = '0;
                o_plan.next.phase = '0;
                line_adv          = 1'b1;
            end
            CH_CR: begin
                o_plan.next.col   = '0;
                o_plan.next.phase = '0;
            end
            default: begin
                o_plan.wr_en = 1'b1;
                if (i_cur.col == COL_W'(COLUMNS - 1)) begin
                    o_plan.next.col   = '0;
                    o_plan.next.phase = '0;
                    line_adv          = 1'b1;
                end else begin
                    o_plan.next.col   = i_cur.col + 1'b1;
                    o_plan.next.phase = (i_cur.phase == TAB_W'(TAB_STOP - 1)) ? '0
                                                                              : i_cur.phase + 1'b1;
                end
            end
        endcase
        if (line_adv) begin
            if (i_cur.row == ROW_W'(ROWS - 1)) begin
                o_plan.scroll = 1'b1;
            end else begin
                o_plan.next.row = i_cur.row + 1'b1;
            end
        end
    end

endmodule

@@ rtl/tcw_seq.sv @@
// ----------------------------------------------------------------------------
// tcw_seq
// Request sequencer: cursor state, store sweeps and the delayed write stage.
// ----------------------------------------------------------------------------
module tcw_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  tcw_pkg::t_req               i_req,
    input  logic [tcw_pkg::CELL_W-1:0]  i_blank_cell,
    output logic                        o_done,
    input  logic                        i_res_free,
    output tcw_pkg::t_result            o_res,
    output tcw_pkg::t_ram_wr            o_wr,
    output tcw_pkg::t_ram_rd            o_rd,
    input  logic [tcw_pkg::CELL_W-1:0]  i_rd_data
);
    import tcw_pkg::*;

    t_state              r_state, n_state;
    t_cursor             r_cur, n_cur;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic                r_w_valid, n_w_valid;
    logic [ADDR_W-1:0]   r_w_addr, n_w_addr;
    logic [CELL_W-1:0]   r_w_data, n_w_data;
    logic                r_w_copy, n_w_copy;
    logic                r_rd_ok, n_rd_ok;
    logic [CELL_W-1:0]   r_cell, n_cell;

    t_put_plan           plan;
    logic                cnt_last;
    logic                idx_ok;

    tcw_cursor u_cursor (
        .i_cur  (r_cur),
        .i_char (i_req.char_code),
        .i_attr ({i_req.back_color, i_req.fore_color}),
        .o_plan (plan)
    );

    assign cnt_last = (r_cnt == ADDR_W'(CELL_COUNT - 1));
    assign idx_ok   = (32'(i_req.cell_index) < CELL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_cur     <= '0;
            r_cnt     <= '0;
            r_w_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_cnt     <= n_cnt;
            r_w_valid <= n_w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_addr <= n_w_addr;
        r_w_data <= n_w_data;
        r_w_copy <= n_w_copy;
        r_rd_ok  <= n_rd_ok;
        r_cell   <= n_cell;
    end

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_cnt     = r_cnt;
        n_w_valid = 1'b0;
        n_w_addr  = r_cnt;
        n_w_data  = i_blank_cell;
        n_w_copy  = 1'b0;
        n_rd_ok   = r_rd_ok;
        n_cell    = r_cell;
        o_rd.en   = 1'b0;
        o_rd.addr = ADDR_W'(i_req.cell_index);
        case (r_state)
            ST_INIT: begin
                n_w_valid = 1'b1;
                n_w_data  = {RESET_ATTR, SPACE_CHAR};
                n_cnt     = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid && !r_w_valid) begin
                    n_cell = '0;
                    case (i_req.req_type)
                        REQ_PUT: begin
                            n_cur     = plan.next;
                            n_w_valid = plan.wr_en;
                            n_w_addr  = plan.wr_addr;
                            n_w_data  = plan.wr_data;
                            n_cnt     = '0;
                            n_state   = plan.scroll ? ST_SCROLL : ST_DONE;
                        end
                        REQ_READ: begin
                            o_rd.en = idx_ok;
                            n_rd_ok = idx_ok;
                            n_state = ST_RD;
                        end
                        REQ_CLEAR: begin
                            n_cur   = '0;
                            n_cnt   = '0;
                            n_state = ST_FILL;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_cell  = r_rd_ok ? i_rd_data : '0;
                n_state = ST_DONE;
            end
            ST_SCROLL: begin
                n_w_valid = 1'b1;
                n_w_copy  = (r_cnt < ADDR_W'(MOVE_COUNT));
                o_rd.en   = n_w_copy;
                o_rd.addr = r_cnt + ADDR_W'(COLUMNS);
                n_cnt     = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_FILL: begin
                n_w_valid = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_wr.en   = r_w_valid;
    assign o_wr.addr = r_w_addr;
    assign o_wr.data = r_w_copy ? i_rd_data : r_w_data;

    assign o_req_ready = (r_state == ST_IDLE) && !r_w_valid;
    assign o_done      = (r_state == ST_DONE);

    assign o_res.cursor_pos = POS_W'(cell_base(r_cur.row) + ADDR_W'(r_cur.col));
    assign o_res.cursor_row = ROW_OUT_W'(r_cur.row);
    assign o_res.cursor_col = COL_OUT_W'(r_cur.col);
    assign o_res.cell_data  = r_cell;

endmodule

@@ rtl/text_console_writer_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console writer: a screen store of character cells and a cursor.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s side    in         tuser: req_type; tdata: char_code, fore_color,
//                       back_color, cell_index
//  m side    out        tdata: cursor_pos, cursor_row, cursor_col, cell_data
//  cfg       in         blank_attribute, written when i_cfg_we is high
//
//  Put without scroll goes from IDLE to DONE; read cell goes through RD to DONE.
//  Scroll and clear sweep the store once, one cell per cycle through the
//  single RAM write port.
//  After reset the store is blanked; no request is taken until the last
//  blank cell is written.
//  The next request is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // char_code[7:0], fore_color[11:8], back_color[15:12], cell_index[26:16]
    input  logic [tcw_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // req_type[1:0]
    input  logic [tcw_pkg::IN_TUSER_W-1:0]     i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // cursor_pos[10:0], cursor_row[15:11], cursor_col[22:16], cell_data[38:23]
    output logic [tcw_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  logic                               i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]         i_cfg_wdata
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] r_blank;
    logic              r_out_valid, n_out_valid;
    t_result           r_out;

    t_req              req;
    t_result           res;
    t_ram_wr           ram_wr;
    t_ram_rd           ram_rd;
    logic [CELL_W-1:0] rd_data;
    logic              done;
    logic              res_free;

    assign req.req_type   = i_s_tuser[1:0];
    assign req.char_code  = i_s_tdata[7:0];
    assign req.fore_color = i_s_tdata[11:8];
    assign req.back_color = i_s_tdata[15:12];
    assign req.cell_index = i_s_tdata[26:16];

    assign res_free = !r_out_valid || i_m_tready;

    tcw_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_tvalid),
        .o_req_ready  (o_s_tready),
        .i_req        (req),
        .i_blank_cell ({r_blank, SPACE_CHAR}),
        .o_done       (done),
        .i_res_free   (res_free),
        .o_res        (res),
        .o_wr         (ram_wr),
        .o_rd         (ram_rd),
        .i_rd_data    (rd_data)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr.en),
        .i_wr_addr (ram_wr.addr),
        .i_wr_data (ram_wr.data),
        .i_rd_en   (ram_rd.en),
        .i_rd_addr (ram_rd.addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (done && res_free) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank     <= RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_blank <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && res_free) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out.cell_data, r_out.cursor_col,
                         r_out.cursor_row, r_out.cursor_pos};

endmodule

@@ rtl/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               o_s_tready,
    input  logic                               o_m_tvalid,
    input  logic [tcw_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import tcw_pkg::*;

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_blanking_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("request taken during store blanking");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while previous one in progress");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[15:11]) < ROWS))
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[22:16]) < COLUMNS))
        else $error("cursor column out of range");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);
